// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, idle while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/frpm_pkg.sv =====
// ----------------------------------------------------------------------------
// frpm_pkg
// Field widths, operation codes and sequencer states of the point matcher.
// ----------------------------------------------------------------------------
package frpm_pkg;

   localparam int LON_WIDTH       = 31;
   localparam int LAT_WIDTH       = 30;
   localparam int THR_WIDTH       = 62;
   localparam int HITS_WIDTH      = 32;
   localparam int ENTRY_WIDTH     = LON_WIDTH + LAT_WIDTH;
   localparam int SQ_LON_WIDTH    = 2 * LON_WIDTH;
   localparam int SQ_LAT_WIDTH    = 2 * LAT_WIDTH;
   localparam int DIST_WIDTH      = SQ_LON_WIDTH + 1;
   localparam int DEFAULT_MAX_REFS = 1024;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

// ===== src/frpm_ram.sv =====
// ----------------------------------------------------------------------------
// frpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fixed_radius_point_match.sv =====
// ----------------------------------------------------------------------------
// fixed_radius_point_match
// Fixed-radius match of a query point against a table of reference points.
// ----------------------------------------------------------------------------
// Loads and clears leave busy low. A query raises busy and streams the
// loaded points out of the point RAM one per cycle through a single distance
// pipeline (abs difference, squares, sum and compare); it ends at the first
// point strictly inside the threshold or after the last loaded point. The
// result is marked on the rsp_ ports by rsp_strobe, high for a single cycle,
// in the same cycle as busy falls; the receiver cannot stall it, and a new
// beat may be started in that cycle. The threshold is to be written through
// csr_ only while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module fixed_radius_point_match
   import frpm_pkg::*;
#(
   parameter int MAX_REFS = DEFAULT_MAX_REFS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_operation,
   input  logic signed [LON_WIDTH-1:0]  req_lon,
   input  logic signed [LAT_WIDTH-1:0]  req_lat,
   output logic                         rsp_strobe,
   output logic                         rsp_matched,
   output logic [HITS_WIDTH-1:0]        rsp_match_count,
   input  logic                         csr_wr_en,
   input  logic [THR_WIDTH-1:0]         csr_wr_data
);

   localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
   localparam int CW = $clog2(MAX_REFS + 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_REFS);

   state_type                state_ff, state_in;
   logic [CW-1:0]            ref_count_ff, ref_count_in;
   logic [HITS_WIDTH-1:0]    hits_ff, hits_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic                     v1_ff, v1_in;
   logic                     v2_ff, v2_in;
   logic                     v3_ff, v3_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic                     matched_ff, matched_in;
   logic [THR_WIDTH-1:0]     thr_ff;
   logic [LON_WIDTH-1:0]     q_lon_ff;
   logic [LAT_WIDTH-1:0]     q_lat_ff;
   logic [LON_WIDTH-1:0]     dlon_ff;
   logic [LAT_WIDTH-1:0]     dlat_ff;
   logic [SQ_LON_WIDTH-1:0]  sq_lon_ff, sq_lon_in;
   logic [SQ_LAT_WIDTH-1:0]  sq_lat_ff, sq_lat_in;

   logic                     accept;
   logic                     load_wr;
   logic                     issue;
   logic                     hit;
   logic [ENTRY_WIDTH-1:0]   rd_entry;
   logic [LON_WIDTH-1:0]     ref_lon;
   logic [LAT_WIDTH-1:0]     ref_lat;
   logic [LON_WIDTH:0]       diff_lon, abs_lon;
   logic [LAT_WIDTH:0]       diff_lat, abs_lat;
   logic [DIST_WIDTH-1:0]    dist_sum;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign load_wr = accept && (req_operation == OP_LOAD) && (ref_count_ff != COUNT_FULL);
   assign issue   = (state_ff == ST_SCAN) && (idx_ff != ref_count_ff);

   frpm_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (MAX_REFS)
   ) u_points (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (ref_count_ff[AW-1:0]),
      .wr_data ({req_lon, req_lat}),
      .rd_en   (issue),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_entry)
   );

   assign ref_lon = rd_entry[ENTRY_WIDTH-1:LAT_WIDTH];
   assign ref_lat = rd_entry[LAT_WIDTH-1:0];

   // signed differences, one bit wider, then magnitude
   assign diff_lon = {q_lon_ff[LON_WIDTH-1], q_lon_ff} - {ref_lon[LON_WIDTH-1], ref_lon};
   assign diff_lat = {q_lat_ff[LAT_WIDTH-1], q_lat_ff} - {ref_lat[LAT_WIDTH-1], ref_lat};
   assign abs_lon  = diff_lon[LON_WIDTH] ? (~diff_lon + 1'b1) : diff_lon;
   assign abs_lat  = diff_lat[LAT_WIDTH] ? (~diff_lat + 1'b1) : diff_lat;

   assign sq_lon_in = dlon_ff * dlon_ff;
   assign sq_lat_in = dlat_ff * dlat_ff;

   assign dist_sum = {1'b0, sq_lon_ff} + {{(DIST_WIDTH - SQ_LAT_WIDTH){1'b0}}, sq_lat_ff};
   assign hit      = v3_ff && (dist_sum < {1'b0, thr_ff});

   always_comb begin
      state_in      = state_ff;
      ref_count_in  = ref_count_ff;
      hits_in       = hits_ff;
      idx_in        = idx_ff;
      rsp_strobe_in = 1'b0;
      matched_in    = matched_ff;
      v1_in         = issue;
      v2_in         = v1_ff;
      v3_in         = v2_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_LOAD: begin
                     if (ref_count_ff != COUNT_FULL) begin
                        ref_count_in = ref_count_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     state_in = ST_SCAN;
                     idx_in   = '0;
                  end
                  OP_CLEAR: begin
                     ref_count_in = '0;
                     hits_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            // first hit ends the scan; otherwise wait for the pipe to drain
            if (hit || (!issue && !v1_ff && !v2_ff && !v3_ff)) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               matched_in    = hit;
               v1_in         = 1'b0;
               v2_in         = 1'b0;
               v3_in         = 1'b0;
               if (hit && (hits_ff != '1)) begin
                  hits_in = hits_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ref_count_ff  <= '0;
         hits_ff       <= '0;
         idx_ff        <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         matched_ff    <= 1'b0;
         thr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         ref_count_ff  <= ref_count_in;
         hits_ff       <= hits_in;
         idx_ff        <= idx_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         v3_ff         <= v3_in;
         rsp_strobe_ff <= rsp_strobe_in;
         matched_ff    <= matched_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_operation == OP_QUERY)) begin
         q_lon_ff <= req_lon;
         q_lat_ff <= req_lat;
      end
      dlon_ff   <= abs_lon[LON_WIDTH-1:0];
      dlat_ff   <= abs_lat[LAT_WIDTH-1:0];
      sq_lon_ff <= sq_lon_in;
      sq_lat_ff <= sq_lat_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_matched     = matched_ff;
   assign rsp_match_count = hits_ff;

   `ASSERT_IMPLY(a_strobe_after_scan, clock, reset, rsp_strobe_ff, $past(state_ff) == ST_SCAN, "result strobe without a scan")
   `ASSERT_IMPLY(a_idle_pipe_empty, clock, reset, state_ff == ST_IDLE, !v1_ff && !v2_ff && !v3_ff, "distance pipe busy while idle")
   `ASSERT_IMPLY(a_match_counted, clock, reset, rsp_strobe_ff && matched_ff, hits_ff != '0, "match beat with zero count")
   `ASSERT_IMPLY(a_index_bounded, clock, reset, state_ff == ST_SCAN, idx_ff <= ref_count_ff, "scan index past loaded points")
   `ASSERT_NEXT(a_scan_holds_table, clock, reset, state_ff == ST_SCAN, ref_count_ff == $past(ref_count_ff), "table size moved during scan")

endmodule
